// ===== rtl/core/pida_pkg.sv =====
// Package for the positional insert/delete array: sizes, request and status codes,
// the command broadcast to the cell row and the result record.
// No dependencies; every other file of the block imports it.
package pida_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 8;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;
  localparam int FILL_W     = 8;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_DATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DATA_W + FILL_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 3'd0,
    REQ_APPEND  = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_DELETE  = 3'd4,
    REQ_READ    = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_WRITE,
    CELL_DELETE,
    CELL_RDLOAD
  } cell_op_t;

  typedef enum logic {
    CS_IDLE,
    CS_READ
  } ctrl_state_t;

  // Command seen by every cell in the same cycle
  typedef struct packed {
    cell_op_t            op;
    logic [CMP_W-1:0]    pos;
    logic [CMP_W-1:0]    cnt;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

  typedef struct packed {
    stat_t               status;
    logic [DATA_W-1:0]   read_value;
    logic [FILL_W-1:0]   fill_count;
  } result_t;

endpackage

// ===== rtl/core/positional_insert_delete_array.sv =====
// Top level of the positional insert/delete array: controller plus a row of
// DEPTH storage cells. Depends on pida_pkg, pida_ctrl and pida_cell.
//
//   channel | direction | payload
//   s_*     | in        | tuser: req_type; tdata: position, value
//   m_*     | out       | tuser: status; tdata: read_value, fill_count
//
// The row of cells shifts all entries in parallel, so clear, append, insert,
// replace and delete requests go back to back.
// A successful read first loads the row's read chain; the entry then walks one
// cell per cycle towards cell 0.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
// Up to two results are buffered; input stalls while a read walks the chain and
// while both slots are taken.
module positional_insert_delete_array (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] position, [39:8] value
  input  logic [pida_pkg::IN_DATA_W-1:0]      s_tdata,
  // [2:0] req_type
  input  logic [pida_pkg::REQ_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] read_value, [39:32] fill_count
  output logic [pida_pkg::OUT_DATA_W-1:0]     m_tdata,
  // [1:0] status
  output logic [pida_pkg::STAT_W-1:0]         m_tuser
);
  import pida_pkg::*;

  cell_cmd_t          cmd;
  result_t            res;
  logic [DATA_W-1:0]  cell_data [DEPTH];
  logic [DATA_W-1:0]  cell_rd   [DEPTH];

  pida_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req       (s_tuser),
    .position  (s_tdata[POS_W-1:0]),
    .value     (s_tdata[POS_W+DATA_W-1:POS_W]),
    .cmd       (cmd),
    .rd_head   (cell_rd[0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d, next_d, rd_nb;

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_lo
      assign prev_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
      assign rd_nb  = '0;
    end else begin : g_mid_hi
      assign next_d = cell_data[i+1];
      assign rd_nb  = cell_rd[i+1];
    end

    pida_cell u_cell (
      .clk       (clk),
      .idx       (CMP_W'(i)),
      .cmd       (cmd),
      .prev_data (prev_d),
      .next_data (next_d),
      .rd_in     (rd_nb),
      .data      (cell_data[i]),
      .rd        (cell_rd[i])
    );
  end

  assign m_tdata = OUT_DATA_W'({res.fill_count, res.read_value});
  assign m_tuser = res.status;

endmodule

// ===== rtl/core/pida_cell.sv =====
// One storage cell of the array row: holds one entry and one slot of the read
// shift chain. Depends on pida_pkg.
module pida_cell (
  input  logic                          clk,
  input  logic [pida_pkg::CMP_W-1:0]    idx,
  input  pida_pkg::cell_cmd_t           cmd,
  input  logic [pida_pkg::DATA_W-1:0]   prev_data,
  input  logic [pida_pkg::DATA_W-1:0]   next_data,
  input  logic [pida_pkg::DATA_W-1:0]   rd_in,
  output logic [pida_pkg::DATA_W-1:0]   data,
  output logic [pida_pkg::DATA_W-1:0]   rd
);
  import pida_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (idx == cmd.pos) begin
          data <= cmd.value;
        end else if (idx > cmd.pos && idx <= cmd.cnt) begin
          data <= prev_data;
        end
      end
      CELL_WRITE: begin
        if (idx == cmd.pos) begin
          data <= cmd.value;
        end
      end
      CELL_DELETE: begin
        // the cell at the old last place takes junk; it drops out of the list
        if (idx >= cmd.pos && idx < cmd.cnt) begin
          data <= next_data;
        end
      end
      default: ;
    endcase
  end

  // load the whole row at once, then shift towards cell 0
  always_ff @(posedge clk) begin
    rd <= (cmd.op == CELL_RDLOAD) ? data : rd_in;
  end

endmodule

// ===== rtl/core/pida_ctrl.sv =====
// Request decoder, fill count, read sequencer and two-deep result buffer.
// Drives the command broadcast to the cell row. Depends on pida_pkg.
module pida_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pida_pkg::REQ_W-1:0]    req,
  input  logic [pida_pkg::POS_W-1:0]    position,
  input  logic [pida_pkg::DATA_W-1:0]   value,
  output pida_pkg::cell_cmd_t           cmd,
  input  logic [pida_pkg::DATA_W-1:0]   rd_head,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pida_pkg::result_t             out_res
);
  import pida_pkg::*;

  ctrl_state_t        state, state_next;
  logic [IDX_W-1:0]   remain, remain_next;
  logic [CNT_W-1:0]   count, count_dec;
  logic [CMP_W-1:0]   pos_ext, cnt_ext;
  logic               full, accept, start_read, push, pop;
  stat_t              dec_status;
  cell_op_t           dec_op;
  logic [CMP_W-1:0]   dec_pos;
  result_t            push_res;
  result_t            q0, q1;
  logic [1:0]         fcnt;

  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(count);
  assign full     = (count == CNT_W'(DEPTH));
  assign in_ready = (state == CS_IDLE) && (fcnt != 2'd2);
  assign accept   = in_valid && in_ready;

  always_comb begin
    dec_status = STAT_DONE;
    dec_op     = CELL_HOLD;
    dec_pos    = pos_ext;
    count_dec  = count;
    start_read = 1'b0;
    unique case (req)
      REQ_CLEAR: begin
        count_dec = '0;
      end
      REQ_APPEND: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_op    = CELL_WRITE;
          dec_pos   = cnt_ext;
          count_dec = count + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (pos_ext > cnt_ext) begin
          dec_status = STAT_RANGE;
        end else if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_op    = CELL_INSERT;
          count_dec = count + CNT_W'(1);
        end
      end
      REQ_REPLACE: begin
        if (pos_ext >= cnt_ext) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_op = CELL_WRITE;
        end
      end
      REQ_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_op    = CELL_DELETE;
          count_dec = count - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (pos_ext >= cnt_ext) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_op     = CELL_RDLOAD;
          start_read = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.op    = accept ? dec_op : CELL_HOLD;
    cmd.pos   = dec_pos;
    cmd.cnt   = cnt_ext;
    cmd.value = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_dec;
    end
  end

  // read sequencer: wait until the wanted entry reaches the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= CS_IDLE;
      remain <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
    end
  end

  always_comb begin
    state_next  = state;
    remain_next = remain;
    push        = 1'b0;
    push_res.status     = dec_status;
    push_res.read_value = '0;
    push_res.fill_count = FILL_W'(count_dec);
    unique case (state)
      CS_IDLE: begin
        if (accept) begin
          if (start_read) begin
            state_next  = CS_READ;
            remain_next = IDX_W'(pos_ext);
          end else begin
            push = 1'b1;
          end
        end
      end
      CS_READ: begin
        push_res.status     = STAT_DONE;
        push_res.read_value = rd_head;
        push_res.fill_count = FILL_W'(count);
        if (remain == '0) begin
          push       = 1'b1;
          state_next = CS_IDLE;
        end else begin
          remain_next = remain - IDX_W'(1);
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // two-deep result buffer: head in q0, skid in q1
  assign out_valid = (fcnt != 2'd0);
  assign out_res   = q0;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   fcnt <= fcnt + 2'd1;
        2'b01:   fcnt <= fcnt - 2'd1;
        default: fcnt <= fcnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (fcnt == 2'd0) begin
          q0 <= push_res;
        end else begin
          q1 <= push_res;
        end
      end
      2'b01: q0 <= q1;
      2'b11: begin
        if (fcnt == 2'd1) begin
          q0 <= push_res;
        end else begin
          q0 <= q1;
          q1 <= push_res;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/pida_check.sv =====
// Port-level checks for positional_insert_delete_array, bound to the top level.
// Depends on pida_pkg.
module pida_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [pida_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [pida_pkg::REQ_W-1:0]          s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [pida_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic [pida_pkg::STAT_W-1:0]         m_tuser
);
  import pida_pkg::*;

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented straight after reset");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STAT_FULL |-> m_tdata[DATA_W+FILL_W-1:DATA_W] == FILL_W'(DEPTH))
    else $error("full status with list not full");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STAT_DONE |-> m_tdata[DATA_W-1:0] == '0)
    else $error("read data on a rejected transaction");

  // hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("request changed while stalled");

endmodule

bind positional_insert_delete_array pida_check u_pida_check (.*);
